/* hdl/ptlt_pkg.sv */
// Package: widths, reset values and shared types of the thick line tessellator.
package ptlt_pkg;

    localparam int CoordWidth = 16;
    localparam int HwWidth    = 12;
    localparam logic [HwWidth-1:0] HwReset = 12'd32;
    localparam int DeltaWidth = CoordWidth + 1;
    localparam int Len2Width  = 2 * DeltaWidth;
    localparam int RadWidth   = Len2Width + 16;
    localparam int RootWidth  = RadWidth / 2;
    localparam int NumWidth   = DeltaWidth + HwWidth + 8;
    localparam int QuotWidth  = HwWidth + 2;
    localparam int TriCount   = 6;
    localparam int TriWidth   = 3;
    localparam logic [TriWidth-1:0] LastTri = 3'(TriCount - 1);

    typedef struct packed {
        logic load_point;
        logic start_seg;
        logic root_step;
        logic div_load;
        logic div_step;
        logic div_done;
        logic emit;
        logic advance;
    } ptlt_cmd_t;

    typedef struct packed {
        logic zero_len;
        logic root_last;
        logic div_last;
        logic div_second;
    } ptlt_stat_t;

endpackage

/* hdl/ptlt_ctrl.sv */
// Controller: sequences load, square root, two divisions and six triangle transfers.
module ptlt_ctrl
    import ptlt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_start,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  logic [TriWidth-1:0] tri_idx,
    input  ptlt_stat_t stat,
    output ptlt_cmd_t  cmd
);

    typedef enum logic [2:0] {ST_IDLE, ST_ROOT, ST_DIVL, ST_DIV, ST_EMIT} state_t;

    state_t state_reg, state_next;
    logic   have_prev_reg, have_prev_next;
    logic   mv_reg, mv_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;

    always_comb begin
        state_next     = state_reg;
        have_prev_next = have_prev_reg;
        mv_next        = mv_reg;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_point = 1'b1;
                    have_prev_next = 1'b1;
                    if (!s_start && have_prev_reg) begin
                        cmd.start_seg = 1'b1;
                        state_next    = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                if (stat.zero_len) begin
                    state_next = ST_EMIT;
                    mv_next    = 1'b1;
                end else begin
                    cmd.root_step = 1'b1;
                    if (stat.root_last) state_next = ST_DIVL;
                end
            end
            ST_DIVL: begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    cmd.div_done = 1'b1;
                    if (stat.div_second) begin
                        state_next = ST_EMIT;
                        mv_next    = 1'b1;
                    end else begin
                        state_next = ST_DIVL;
                    end
                end
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (m_tready) begin
                    cmd.advance = 1'b1;
                    if (tri_idx == LastTri) begin
                        mv_next    = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            have_prev_reg <= 1'b0;
            mv_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            mv_reg        <= mv_next;
        end
    end

endmodule

/* hdl/ptlt_dpath.sv */
// Datapath: segment delta, bit-serial square root and division, strip vertex selection.
module ptlt_dpath
    import ptlt_pkg::*;
(
    input  logic                  aclk,
    input  ptlt_cmd_t             cmd,
    output ptlt_stat_t            stat,
    input  logic [HwWidth-1:0]    hw,
    input  logic [CoordWidth-1:0] in_x,
    input  logic [CoordWidth-1:0] in_y,
    output logic [TriWidth-1:0]   tri_idx,
    output logic [6*CoordWidth-1:0] verts
);

    localparam int RootSteps = RootWidth;
    localparam int RcWidth   = $clog2(RootSteps + 1);
    localparam int DivSteps  = NumWidth;
    localparam int DcWidth   = $clog2(DivSteps + 1);
    localparam int VWidth    = CoordWidth + 4;
    localparam int ProdWidth = DeltaWidth + HwWidth;

    logic signed [CoordWidth-1:0] px_reg, py_reg, sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [DeltaWidth-1:0] dx_reg, dy_reg;
    logic [HwWidth-1:0]           hw_reg;
    logic [RadWidth-1:0]          rad_reg;
    logic [RootWidth+1:0]         rem_reg;
    logic [RootWidth-1:0]         root_reg;
    logic [RcWidth-1:0]           rcnt_reg;
    logic [NumWidth-1:0]          num_reg;
    logic [NumWidth+1:0]          drem_reg;
    logic [QuotWidth-1:0]         quo_reg;
    logic [DcWidth-1:0]           dcnt_reg;
    logic                         dsel_reg, dneg_reg;
    logic signed [QuotWidth:0]    ox_reg, oy_reg;
    logic [TriWidth-1:0]          tri_reg;
    logic                         zero_reg;

    logic [RootWidth+1:0] rtrial;
    logic [RootWidth+1:0] rshift;
    logic [NumWidth+1:0]  dshift;
    logic [NumWidth+1:0]  dden;
    logic [NumWidth-1:0]  dnum;
    logic signed [DeltaWidth-1:0] dsel;
    logic [DeltaWidth-1:0] dmag;
    logic [ProdWidth-1:0]  prod;
    logic [Len2Width-1:0]  len2;
    logic [2*DeltaWidth-1:0] sqx, sqy;

    assign sqx  = (2*DeltaWidth)'(dx_reg * dx_reg);
    assign sqy  = (2*DeltaWidth)'(dy_reg * dy_reg);
    assign len2 = Len2Width'(sqx) + Len2Width'(sqy);

    assign rshift = {rem_reg[RootWidth-1:0], rad_reg[RadWidth-1 -: 2]};
    assign rtrial = {root_reg, 2'b01};

    assign dsel  = dsel_reg ? dy_reg : dx_reg;
    assign dmag  = dsel[DeltaWidth-1] ? DeltaWidth'(-dsel) : DeltaWidth'(dsel);
    assign prod  = ProdWidth'(dmag) * ProdWidth'(hw_reg);
    assign dnum  = {prod[ProdWidth-2:0], 9'd0};
    assign dden  = (NumWidth+2)'({root_reg, 1'b0});
    assign dshift = {drem_reg[NumWidth:0], num_reg[NumWidth-1]};

    assign stat.zero_len   = zero_reg;
    assign stat.root_last  = (rcnt_reg == RcWidth'(RootSteps - 1));
    assign stat.div_last   = (dcnt_reg == DcWidth'(DivSteps - 1));
    assign stat.div_second = dsel_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_point) begin
            px_reg <= in_x;
            py_reg <= in_y;
        end
        if (cmd.start_seg) begin
            sx_reg   <= px_reg;
            sy_reg   <= py_reg;
            ex_reg   <= in_x;
            ey_reg   <= in_y;
            dx_reg   <= DeltaWidth'($signed(in_x)) - DeltaWidth'($signed(px_reg));
            dy_reg   <= DeltaWidth'($signed(in_y)) - DeltaWidth'($signed(py_reg));
            zero_reg <= (in_x == px_reg) && (in_y == py_reg);
            hw_reg   <= hw;
            rcnt_reg <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            dsel_reg <= 1'b0;
            tri_reg  <= '0;
            ox_reg   <= (QuotWidth+1)'(hw);
            oy_reg   <= '0;
        end
        if (cmd.root_step) begin
            if (rcnt_reg == '0) begin
                rad_reg <= {len2, 16'd0} << 2;
                if ({2'b00, len2[Len2Width-1 -: 2]} >= 4'd1) begin
                    rem_reg  <= (RootWidth+2)'(len2[Len2Width-1 -: 2]) - 1'b1;
                    root_reg <= RootWidth'(1);
                end else begin
                    rem_reg  <= (RootWidth+2)'(len2[Len2Width-1 -: 2]);
                    root_reg <= '0;
                end
            end else begin
                rad_reg <= rad_reg << 2;
                if (rshift >= rtrial) begin
                    rem_reg  <= rshift - rtrial;
                    root_reg <= {root_reg[RootWidth-2:0], 1'b1};
                end else begin
                    rem_reg  <= rshift;
                    root_reg <= {root_reg[RootWidth-2:0], 1'b0};
                end
            end
            rcnt_reg <= rcnt_reg + 1'b1;
        end
        if (cmd.div_load) begin
            num_reg  <= dnum + NumWidth'(root_reg);
            drem_reg <= '0;
            quo_reg  <= '0;
            dcnt_reg <= '0;
            dneg_reg <= dsel[DeltaWidth-1];
        end
        if (cmd.div_step) begin
            num_reg  <= num_reg << 1;
            dcnt_reg <= dcnt_reg + 1'b1;
            if (dshift >= dden) begin
                drem_reg <= dshift - dden;
                quo_reg  <= {quo_reg[QuotWidth-2:0], 1'b1};
            end else begin
                drem_reg <= dshift;
                quo_reg  <= {quo_reg[QuotWidth-2:0], 1'b0};
            end
        end
        if (cmd.div_done) begin
            if (dsel_reg) oy_reg <= dneg_reg ? -$signed({1'b0, quo_reg[QuotWidth-2:0],
                                        dshift >= dden}) : $signed({1'b0,
                                        quo_reg[QuotWidth-2:0], dshift >= dden});
            else          ox_reg <= dneg_reg ? -$signed({1'b0, quo_reg[QuotWidth-2:0],
                                        dshift >= dden}) : $signed({1'b0,
                                        quo_reg[QuotWidth-2:0], dshift >= dden});
            dsel_reg <= 1'b1;
        end
        if (cmd.advance) tri_reg <= tri_reg + 1'b1;
    end

    assign tri_idx = tri_reg;

    function automatic logic [CoordWidth-1:0] sat(input logic signed [VWidth-1:0] v);
        if (v > VWidth'(32767))       return 16'h7fff;
        else if (v < -VWidth'(32768)) return 16'h8000;
        else                          return v[CoordWidth-1:0];
    endfunction

    function automatic logic [2*CoordWidth-1:0] vtx(
        input logic [TriWidth-1:0] k,
        input logic signed [CoordWidth-1:0] sx, sy, ex, ey,
        input logic signed [QuotWidth:0] ox, oy);
        logic signed [VWidth-1:0] bx, by, nx, ny, vx, vy;
        bx = VWidth'(k[2] ? ex : sx);
        by = VWidth'(k[2] ? ey : sy);
        if (k[2:1] == 2'd0) begin
            bx = bx - VWidth'(ox);
            by = by - VWidth'(oy);
        end else if (k[2:1] == 2'd3) begin
            bx = bx + VWidth'(ox);
            by = by + VWidth'(oy);
        end
        nx = k[0] ? -VWidth'(oy) : VWidth'(oy);
        ny = k[0] ? VWidth'(ox) : -VWidth'(ox);
        vx = bx + nx;
        vy = by + ny;
        return {sat(vy), sat(vx)};
    endfunction

    assign verts[2*CoordWidth-1:0] =
        vtx(tri_reg, sx_reg, sy_reg, ex_reg, ey_reg, ox_reg, oy_reg);
    assign verts[4*CoordWidth-1:2*CoordWidth] =
        vtx(tri_reg + 3'd1, sx_reg, sy_reg, ex_reg, ey_reg, ox_reg, oy_reg);
    assign verts[6*CoordWidth-1:4*CoordWidth] =
        vtx(tri_reg + 3'd2, sx_reg, sy_reg, ex_reg, ey_reg, ox_reg, oy_reg);

endmodule

/* hdl/polyline_thick_line_tessellator.sv */
// Top level of the thick polyline tessellator with square caps.
// Each point that closes a segment yields six triangle transfers; a shape start
// or the first point after reset is stored in its accept cycle and yields none.
// A segment takes its accept cycle, a bit-serial square root, two
// bit-serial divisions of 37 steps after a load state each, then six output
// transfers; no new point is accepted until the last of them is taken. A
// zero-length segment skips the root and the divisions.
// Output stalls add their length. half_line_width is sampled when a segment starts.
module polyline_thick_line_tessellator
    import ptlt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,      // half_line_width in [11:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // point_x, point_y
    input  logic        s_tuser,       // shape_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [103:0] m_tdata,      // tri_index, a_x, a_y, b_x, b_y, c_x, c_y, zero fill
    output logic        m_tlast        // last_of_segment
);

    logic [HwWidth-1:0]   hw_reg;
    ptlt_cmd_t            cmd;
    ptlt_stat_t           stat;
    logic [TriWidth-1:0]  tri_idx;
    logic [6*CoordWidth-1:0] verts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) hw_reg <= HwReset;
        else if (cfg_valid) hw_reg <= cfg_data[HwWidth-1:0];
    end

    ptlt_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_start(s_tuser),
        .m_tvalid, .m_tready, .tri_idx, .stat, .cmd
    );

    ptlt_dpath u_dpath (
        .aclk, .cmd, .stat, .hw(hw_reg),
        .in_x(s_tdata[15:0]), .in_y(s_tdata[31:16]), .tri_idx, .verts
    );

    assign m_tdata = {5'd0, verts, tri_idx};
    assign m_tlast = (tri_idx == LastTri);

endmodule
